// File: rtl/core/itl_pkg.sv
// ----------------------------------------------------------------------------
// itl_pkg - shared types and constants of the interpolating table lookup
// Opcodes, status codes, item classes and the sequencer states of the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itl_pkg;

	localparam int DEF_TABLE_DEPTH   = 1024;
	localparam int DEF_SAMPLE_BITS   = 16;
	localparam int DEF_FRACTION_BITS = 16;

	// step index and step total are fixed 16-bit fields
	localparam int STEP_BITS = 16;

	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int RES_QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QPOS   = 2'd2,
		OP_QSTEP  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_CLAMP = 2'd3
	} status_t;

	// what the back end has to do with a queued item
	typedef enum logic [1:0] {
		K_REPORT = 2'd0,
		K_APPEND = 2'd1,
		K_QPOS   = 2'd2,
		K_QSTEP  = 2'd3
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		status_t    status;
	} item_ctl_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_CLAMP,
		BK_RD1,
		BK_RD2,
		BK_CAP,
		BK_PROD,
		BK_DONE
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/itl_ram.sv
// ----------------------------------------------------------------------------
// itl_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/itl_queue.sv
// ----------------------------------------------------------------------------
// itl_queue - small register FIFO
// Used between front and back end and as the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itl_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/itl_front.sv
// ----------------------------------------------------------------------------
// itl_front - transaction intake and classification
// Keeps entry count and running min/max, tags each item for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itl_front import itl_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int CNT_BITS    = $clog2(DEF_TABLE_DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    opcode,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
	output item_ctl_t                          ctl,
	output logic      [CNT_BITS-1:0]           count_nx,
	output logic signed [SAMPLE_BITS-1:0]      low_nx,
	output logic signed [SAMPLE_BITS-1:0]      high_nx
);

	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	logic      [CNT_BITS-1:0]    count_q;
	logic signed [SAMPLE_BITS-1:0] low_q;
	logic signed [SAMPLE_BITS-1:0] high_q;

	// snapshot after the item; the back end reports exactly this
	always_comb begin
		ctl      = '{kind: K_REPORT, status: ST_OK};
		count_nx = count_q;
		low_nx   = low_q;
		high_nx  = high_q;
		unique case (opcode_t'(opcode))
			OP_CLEAR: begin
				count_nx = '0;
				low_nx   = SMAX;
				high_nx  = SMIN;
			end
			OP_APPEND: begin
				if (count_q == CNT_BITS'(TABLE_DEPTH)) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.kind = K_APPEND;
					count_nx = count_q + 1'b1;
					if (sample_value < low_q) low_nx = sample_value;
					if (sample_value > high_q) high_nx = sample_value;
				end
			end
			OP_QPOS, OP_QSTEP: begin
				if (count_q == '0) begin
					ctl.status = ST_EMPTY;
				end else begin
					ctl.kind = (opcode_t'(opcode) == OP_QPOS) ? K_QPOS : K_QSTEP;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			low_q   <= SMAX;
			high_q  <= SMIN;
		end else if (accept) begin
			count_q <= count_nx;
			low_q   <= low_nx;
			high_q  <= high_nx;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/itl_back.sv
// ----------------------------------------------------------------------------
// itl_back - item execution
// Table writes, step-to-position divide, clamp and linear interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itl_back import itl_pkg::*; #(
	parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS,
	parameter int IDX_BITS      = $clog2(DEF_TABLE_DEPTH),
	parameter int CNT_BITS      = $clog2(DEF_TABLE_DEPTH + 1),
	parameter int POS_BITS      = $clog2(DEF_TABLE_DEPTH) + DEF_FRACTION_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command queue head
	input  wire logic                          q_empty,
	output logic                               q_pop,
	input  wire item_ctl_t                     q_ctl,
	input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
	input  wire logic [POS_BITS-1:0]           q_position,
	input  wire logic [STEP_BITS-1:0]          q_step,
	input  wire logic [CNT_BITS-1:0]           q_count,
	input  wire logic signed [SAMPLE_BITS-1:0] q_low,
	input  wire logic signed [SAMPLE_BITS-1:0] q_high,
	// step total register
	input  wire logic [STEP_BITS-1:0]          step_total,
	// result queue
	input  wire logic                          res_full,
	output logic                               res_push,
	output logic signed [SAMPLE_BITS-1:0]      res_value,
	output logic signed [SAMPLE_BITS-1:0]      res_low,
	output logic signed [SAMPLE_BITS-1:0]      res_high,
	output logic      [CNT_BITS-1:0]           res_count,
	output status_t                            res_status
);

	localparam int PROD_BITS = STEP_BITS + IDX_BITS;
	localparam int DVD_BITS  = PROD_BITS + FRACTION_BITS;
	localparam int DCW       = $clog2(DVD_BITS);
	localparam int MULW      = FRACTION_BITS + SAMPLE_BITS + 2;
	localparam logic signed [MULW-1:0] HALF = MULW'(1) << (FRACTION_BITS - 1);

	back_state_t state_q, state_nx;

	item_kind_t                    kind_q;
	status_t                       status_q;
	logic      [CNT_BITS-1:0]      count_q;
	logic signed [SAMPLE_BITS-1:0] low_q;
	logic signed [SAMPLE_BITS-1:0] high_q;
	logic      [IDX_BITS-1:0]      last_q;
	logic      [STEP_BITS-1:0]     step_q;
	logic      [PROD_BITS-1:0]     ip_q;
	logic      [FRACTION_BITS-1:0] fr_q;
	logic                          clamped_q;
	logic      [IDX_BITS-1:0]      idx1_q;
	logic      [IDX_BITS-1:0]      idx2_q;
	logic signed [SAMPLE_BITS-1:0] y1_q;
	logic signed [SAMPLE_BITS-1:0] y2_q;
	logic signed [MULW-1:0]        prod_q;
	logic      [DVD_BITS-1:0]      dvd_q;
	logic      [STEP_BITS-1:0]     rem_q;
	logic      [DCW-1:0]           div_cnt_q;

	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic [IDX_BITS-1:0]   ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	// divider step
	logic [STEP_BITS-1:0] divisor;
	logic [STEP_BITS:0]   trial;
	logic                 qbit;
	logic [STEP_BITS-1:0] rem_nx;
	logic [DVD_BITS-1:0]  dvd_nx;

	// clamp
	logic                over;
	logic [IDX_BITS-1:0] idx1_c;
	logic [IDX_BITS-1:0] idx2_c;

	// interpolation
	logic signed [MULW-1:0] fr_ext;
	logic signed [MULW-1:0] diff_ext;
	logic signed [MULW-1:0] rnd;
	logic signed [MULW-1:0] interp;

	itl_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(q_sample),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign divisor = (step_total == '0) ? STEP_BITS'(1) : step_total;
	assign trial   = {rem_q, dvd_q[DVD_BITS-1]};
	assign qbit    = (trial >= {1'b0, divisor});
	assign rem_nx  = qbit ? STEP_BITS'(trial - {1'b0, divisor}) : trial[STEP_BITS-1:0];
	assign dvd_nx  = {dvd_q[DVD_BITS-2:0], qbit};

	assign over   = (ip_q > PROD_BITS'(last_q));
	assign idx1_c = over ? last_q : ip_q[IDX_BITS-1:0];
	assign idx2_c = (idx1_c < last_q) ? idx1_c + 1'b1 : '0;

	assign fr_ext   = MULW'($signed({1'b0, fr_q}));
	assign diff_ext = MULW'(y2_q) - MULW'(y1_q);
	assign rnd      = prod_q + HALF;
	assign interp   = MULW'(y1_q) + (rnd >>> FRACTION_BITS);

	assign ram_waddr = IDX_BITS'(q_count - 1'b1);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					unique case (q_ctl.kind)
						K_QPOS:  state_nx = BK_CLAMP;
						K_QSTEP: state_nx = BK_MUL;
						default: state_nx = BK_DONE;
					endcase
				end
			end
			BK_MUL:   state_nx = BK_DIV;
			BK_DIV:   if (div_cnt_q == '0) state_nx = BK_CLAMP;
			BK_CLAMP: state_nx = BK_RD1;
			BK_RD1:   state_nx = BK_RD2;
			BK_RD2:   state_nx = BK_CAP;
			BK_CAP:   state_nx = BK_PROD;
			BK_PROD:  state_nx = BK_DONE;
			BK_DONE:  if (!res_full) state_nx = BK_IDLE;
			default:  state_nx = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop     = (state_q == BK_IDLE) && !q_empty;
		ram_we    = q_pop && (q_ctl.kind == K_APPEND);
		ram_raddr = (state_q == BK_RD2) ? idx2_q : idx1_q;
		res_push  = (state_q == BK_DONE) && !res_full;
	end

	assign res_value  = (kind_q == K_QPOS || kind_q == K_QSTEP) ?
	                    SAMPLE_BITS'(interp) : '0;
	assign res_low    = low_q;
	assign res_high   = high_q;
	assign res_count  = count_q;
	assign res_status = clamped_q ? ST_CLAMP : status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					kind_q    <= q_ctl.kind;
					status_q  <= q_ctl.status;
					count_q   <= q_count;
					low_q     <= q_low;
					high_q    <= q_high;
					last_q    <= IDX_BITS'(q_count - 1'b1);
					step_q    <= q_step;
					ip_q      <= PROD_BITS'(q_position[POS_BITS-1:FRACTION_BITS]);
					fr_q      <= q_position[FRACTION_BITS-1:0];
					clamped_q <= 1'b0;
				end
			end
			BK_MUL: begin
				dvd_q     <= {PROD_BITS'(step_q) * PROD_BITS'(last_q),
				              FRACTION_BITS'(0)};
				rem_q     <= '0;
				div_cnt_q <= DCW'(DVD_BITS - 1);
			end
			BK_DIV: begin
				dvd_q     <= dvd_nx;
				rem_q     <= rem_nx;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == '0) begin
					ip_q <= dvd_nx[DVD_BITS-1:FRACTION_BITS];
					fr_q <= dvd_nx[FRACTION_BITS-1:0];
				end
			end
			BK_CLAMP: begin
				idx1_q    <= idx1_c;
				idx2_q    <= idx2_c;
				clamped_q <= over;
				if (over) fr_q <= '0;
			end
			BK_RD2:  y1_q   <= ram_rdata;
			BK_CAP:  y2_q   <= ram_rdata;
			BK_PROD: prod_q <= fr_ext * diff_ext;
			default: ;
		endcase
	end

	// table reads never leave the filled part
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_RD1 |-> (idx1_q <= last_q) && (idx2_q <= last_q))
		else $error("itl_back: table index beyond last entry");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("itl_back: result pushed into full queue");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV && div_cnt_q == '0) |=> state_q == BK_CLAMP)
		else $error("itl_back: divider did not hand over to clamp");

	a_clamp_query_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DONE && kind_q != K_QPOS && kind_q != K_QSTEP) |-> !clamped_q)
		else $error("itl_back: clamp flag on a non-query item");

endmodule

`default_nettype wire

// File: rtl/core/interpolating_table_lookup.sv
// ----------------------------------------------------------------------------
// interpolating_table_lookup - sample table with linear interpolation
// Appends samples, tracks min/max, answers position and step queries.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands go in through a queue-style port: a transaction is taken on a
//    clock edge with push high and full low. Each command yields exactly one
//    result, in order, on the result port: the oldest result is shown while
//    empty is low and is taken on an edge with pop high.
//  - step_total is written with step_total_we; write it only while idle.
//    A value of zero acts as one.
//  - A front end updates count and min/max at accept time and queues the
//    command (4 deep); a back end sequencer executes it and feeds a 2-deep
//    result queue, so intake runs on while results wait.
//  - The back end takes one command at a time: clear, append and rejected
//    commands go straight to the result, a position query is clamped and
//    interpolated, and a step query first runs the bit-serial divider that
//    turns a step into a position. Interpolation reads the table RAM
//    twice through one read port.
//  - A stalled receiver fills the result queue, then the back end holds its
//    finished result, then the command queue fills and full rises.
//  - Reset empties both queues and the table, min goes to the most positive
//    and max to the most negative sample, step_total goes to one. The table
//    RAM itself is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interpolating_table_lookup import itl_pkg::*; #(
	parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS,
	parameter int IDX_BITS      = $clog2(TABLE_DEPTH),
	parameter int CNT_BITS      = $clog2(TABLE_DEPTH + 1),
	parameter int POS_BITS      = $clog2(TABLE_DEPTH) + FRACTION_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command transactions
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [1:0]                    opcode,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
	input  wire logic [POS_BITS-1:0]           position,
	input  wire logic [STEP_BITS-1:0]          step_index,
	// step total register
	input  wire logic                          step_total_we,
	input  wire logic [STEP_BITS-1:0]          step_total,
	// result transactions
	output logic                               empty,
	input  wire logic                          pop,
	output logic signed [SAMPLE_BITS-1:0]      interpolated_value,
	output logic signed [SAMPLE_BITS-1:0]      lowest_value,
	output logic signed [SAMPLE_BITS-1:0]      highest_value,
	output logic      [CNT_BITS-1:0]           entry_count,
	output logic      [1:0]                    status
);

	localparam int CTL_BITS = $bits(item_ctl_t);
	localparam int CMD_W    = CTL_BITS + SAMPLE_BITS + POS_BITS + STEP_BITS
	                        + CNT_BITS + 2 * SAMPLE_BITS;
	localparam int RES_W    = 3 * SAMPLE_BITS + CNT_BITS + 2;

	logic [STEP_BITS-1:0] step_total_q;

	logic                          accept;
	item_ctl_t                     f_ctl;
	logic      [CNT_BITS-1:0]      f_count;
	logic signed [SAMPLE_BITS-1:0] f_low;
	logic signed [SAMPLE_BITS-1:0] f_high;

	logic [CMD_W-1:0] cmd_wdata;
	logic [CMD_W-1:0] cmd_rdata;
	logic             cmd_empty;
	logic             cmd_pop;

	item_ctl_t                     q_ctl;
	logic signed [SAMPLE_BITS-1:0] q_sample;
	logic      [POS_BITS-1:0]      q_position;
	logic      [STEP_BITS-1:0]     q_step;
	logic      [CNT_BITS-1:0]      q_count;
	logic signed [SAMPLE_BITS-1:0] q_low;
	logic signed [SAMPLE_BITS-1:0] q_high;

	logic                          res_full;
	logic                          res_push;
	logic signed [SAMPLE_BITS-1:0] r_value;
	logic signed [SAMPLE_BITS-1:0] r_low;
	logic signed [SAMPLE_BITS-1:0] r_high;
	logic      [CNT_BITS-1:0]      r_count;
	status_t                       r_status;
	logic [RES_W-1:0]              res_wdata;
	logic [RES_W-1:0]              res_rdata;

	// step total register, reset to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_total_q <= STEP_BITS'(1);
		end else if (step_total_we) begin
			step_total_q <= step_total;
		end
	end

	assign accept = push && !full;

	itl_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CNT_BITS   (CNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.opcode      (opcode),
		.sample_value(sample_value),
		.ctl         (f_ctl),
		.count_nx    (f_count),
		.low_nx      (f_low),
		.high_nx     (f_high)
	);

	// command queue: classified item plus state snapshot
	assign cmd_wdata = {f_ctl, sample_value, position, step_index, f_count, f_low, f_high};

	itl_queue #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data(cmd_wdata),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rdata),
		.empty  (cmd_empty)
	);

	assign {q_ctl, q_sample, q_position, q_step, q_count, q_low, q_high} = cmd_rdata;

	itl_back #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.IDX_BITS     (IDX_BITS),
		.CNT_BITS     (CNT_BITS),
		.POS_BITS     (POS_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (cmd_empty),
		.q_pop     (cmd_pop),
		.q_ctl     (q_ctl),
		.q_sample  (q_sample),
		.q_position(q_position),
		.q_step    (q_step),
		.q_count   (q_count),
		.q_low     (q_low),
		.q_high    (q_high),
		.step_total(step_total_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_value (r_value),
		.res_low   (r_low),
		.res_high  (r_high),
		.res_count (r_count),
		.res_status(r_status)
	);

	// result queue decouples the receiver from the sequencer
	assign res_wdata = {r_value, r_low, r_high, r_count, r_status};

	itl_queue #(
		.WIDTH(RES_W),
		.DEPTH(RES_QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_wdata),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_rdata),
		.empty  (empty)
	);

	assign {interpolated_value, lowest_value, highest_value, entry_count, status} = res_rdata;

endmodule

`default_nettype wire

// File: verif/tb_interpolating_table_lookup.sv
// ----------------------------------------------------------------------------
// tb_interpolating_table_lookup - self-checking bench for the table lookup
// Drives clear/append/query transactions through the queue-style ports, keeps
// its own copy of the table, count, min/max and step total, and checks every
// result field against the predicted value, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_interpolating_table_lookup;
	import itl_pkg::*;

	localparam int DEPTH        = DEF_TABLE_DEPTH;
	localparam int FRAC         = DEF_FRACTION_BITS;
	localparam int POS_W        = $clog2(DEF_TABLE_DEPTH) + DEF_FRACTION_BITS;
	localparam int CNT_W        = $clog2(DEF_TABLE_DEPTH + 1);
	localparam int LONG_HOLD    = 300;  // receiver stall, well past queue depth
	localparam int DRAIN_CYCLES = 80;   // final drain; outlasts a step query from accept to result
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		opcode_t            op;
		logic signed [15:0] smp;
		logic [POS_W-1:0]   pos;
		logic [15:0]        idx;
	} lookup_cmd_t;

	typedef struct {
		logic signed [15:0] value;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic [CNT_W-1:0]   cnt;
		status_t            st;
	} lookup_result_t;

	// DUT signals; every input is known from time zero
	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 push          = 1'b0;
	logic                 full;
	logic [1:0]           opcode        = '0;
	logic signed [15:0]   sample_value  = '0;
	logic [POS_W-1:0]     position      = '0;
	logic [15:0]          step_index    = '0;
	logic                 step_total_we = 1'b0;
	logic [15:0]          step_total    = 16'd1;
	logic                 empty;
	logic                 pop           = 1'b0;
	logic signed [15:0]   interpolated_value;
	logic signed [15:0]   lowest_value;
	logic signed [15:0]   highest_value;
	logic [CNT_W-1:0]     entry_count;
	logic [1:0]           status;

	// stimulus and expectation stores
	lookup_cmd_t    command_q[$];
	lookup_result_t answer_q[$];

	// predictor state: table, fill count, running extremes, step total register
	logic signed [15:0] samples [DEPTH];
	int unsigned        n_samples;
	logic signed [15:0] run_min;
	logic signed [15:0] run_max;
	logic [15:0]        step_count_cfg;

	// idle control, owned by the main sequence
	int send_idle_pct;
	int recv_idle_pct;
	int hold_token = 0;

	// receiver-side hold bookkeeping, owned by the receiver process
	int hold_seen = 0;
	int hold_left = 0;

	// run statistics
	int mismatches   = 0;
	int accepted     = 0;
	int checked      = 0;
	int full_cycles  = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	interpolating_table_lookup u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.opcode             (opcode),
		.sample_value       (sample_value),
		.position           (position),
		.step_index         (step_index),
		.step_total_we      (step_total_we),
		.step_total         (step_total),
		.empty              (empty),
		.pop                (pop),
		.interpolated_value (interpolated_value),
		.lowest_value       (lowest_value),
		.highest_value      (highest_value),
		.entry_count        (entry_count),
		.status             (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Safety net: the slowest legal run is well under a tenth of this.
	initial begin
		#(64'd8_000_000);
		$display("Timeout: %0d transactions still pending", answer_q.size());
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor: applies one accepted transaction to the shadow state and
	// returns the result the block must produce for it.
	// ------------------------------------------------------------------------
	function automatic lookup_result_t apply_command(input opcode_t op,
			input logic signed [15:0] smp, input logic [POS_W-1:0] pos_in,
			input logic [15:0] idx);
		lookup_result_t    r;
		longint unsigned   pos, last, ip, fr, nx, divisor;
		longint            y1, y2, prod;
		r.value = '0;
		r.st    = ST_OK;
		case (op)
			OP_CLEAR: begin
				n_samples = 0;
				run_min   = 16'sh7FFF;
				run_max   = 16'sh8000;
			end
			OP_APPEND: begin
				if (n_samples >= DEPTH) begin
					r.st = ST_FULL;   // sample dropped, state untouched
				end else begin
					samples[n_samples] = smp;
					n_samples++;
					if (smp < run_min) run_min = smp;
					if (smp > run_max) run_max = smp;
				end
			end
			default: begin
				if (n_samples == 0) begin
					r.st = ST_EMPTY;
				end else begin
					if (op == OP_QPOS) begin
						pos = 64'(pos_in);
					end else begin
						// register value zero acts as one; truncating divide
						divisor = (step_count_cfg == 0) ? 64'd1 : 64'(step_count_cfg);
						pos = ((64'(idx) * 64'(n_samples - 1)) << FRAC) / divisor;
					end
					last = 64'(n_samples - 1);
					ip   = pos >> FRAC;
					fr   = pos & ((64'd1 << FRAC) - 1);
					if (ip > last) begin
						ip   = last;
						fr   = 0;
						r.st = ST_CLAMP;
					end
					// integer part on the last entry blends toward entry 0
					nx   = (ip < last) ? ip + 1 : 64'd0;
					y1   = samples[ip];
					y2   = samples[nx];
					prod = longint'(fr) * (y2 - y1);
					// round half toward +inf, arithmetic shift gives the floor
					r.value = 16'(y1 + ((prod + (64'sd1 <<< (FRAC - 1))) >>> FRAC));
				end
			end
		endcase
		r.lo  = run_min;
		r.hi  = run_max;
		r.cnt = CNT_W'(n_samples);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers. Fields the opcode does not use still get random bits.
	// ------------------------------------------------------------------------
	function automatic void add_cmd(input opcode_t op, input logic [15:0] smp,
			input logic [POS_W-1:0] pos, input logic [15:0] idx);
		lookup_cmd_t c;
		c.op  = op;
		c.smp = (op == OP_APPEND) ? smp : 16'($urandom);
		c.pos = (op == OP_QPOS)   ? pos : POS_W'($urandom);
		c.idx = (op == OP_QSTEP)  ? idx : 16'($urandom);
		command_q.push_back(c);
	endfunction

	function automatic logic [15:0] rand_sample();
		if ($urandom_range(7) != 0) return 16'($urandom);
		case ($urandom_range(3))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// mostly inside or just past the table, sometimes anywhere
	function automatic logic [POS_W-1:0] rand_pos(input int cnt);
		logic [15:0] frac;
		int          ip;
		if ($urandom_range(4) == 0) return POS_W'($urandom);
		ip = $urandom_range(cnt);
		case ($urandom_range(7))
			0, 1:    frac = 16'h0000;
			2:       frac = 16'hFFFF;
			3:       frac = 16'h8000;
			default: frac = 16'($urandom);
		endcase
		return {10'(ip), frac};
	endfunction

	// mostly 0..total+1 so the clamp edge gets hit, sometimes anywhere
	function automatic logic [15:0] rand_step();
		int top;
		if ($urandom_range(4) == 0) return 16'($urandom);
		top = (step_count_cfg == 0) ? 2 : int'(step_count_cfg) + 1;
		if (top > 65535) top = 65535;
		return 16'($urandom_range(top));
	endfunction

	// Well-formed sessions: clear, runs of appends, queries over what was
	// built. A slice of raw noise items mixes in broken sequences.
	task automatic plan_session(input int n_items);
		int planned;
		int left;
		int run;
		int r;
		int k;
		planned = 0;
		left    = n_items - 1;
		add_cmd(OP_CLEAR, '0, '0, '0);
		while (left > 0) begin
			r = $urandom_range(99);
			if (r < 5 || (planned > 80 && r < 25)) begin
				add_cmd(OP_CLEAR, '0, '0, '0);
				planned = 0;
				left--;
			end else if (r < 10) begin
				k = $urandom_range(3);
				add_cmd(opcode_t'(k), 16'($urandom), POS_W'($urandom), 16'($urandom));
				if (k == OP_CLEAR) planned = 0;
				else if (k == OP_APPEND && planned < DEPTH) planned++;
				left--;
			end else if (r < 45) begin
				run = $urandom_range(1, 8);
				for (k = 0; k < run && left > 0; k++) begin
					add_cmd(OP_APPEND, rand_sample(), '0, '0);
					planned++;
					left--;
				end
			end else if (r < 72) begin
				add_cmd(OP_QPOS, '0, rand_pos(planned), '0);
				left--;
			end else begin
				add_cmd(OP_QSTEP, '0, '0, rand_step());
				left--;
			end
		end
	endtask

	// sender pause: nothing queued, nothing outstanding
	task automatic wait_drained();
		while (command_q.size() != 0 || answer_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write while idle; the shadow copy follows the write edge
	task automatic set_step_total(input logic [15:0] v);
		@(negedge clk);
		step_total_we <= 1'b1;
		step_total    <= v;
		@(negedge clk);
		step_total_we <= 1'b0;
		step_count_cfg = v;
	endtask

	// ------------------------------------------------------------------------
	// Driver: offers the head of command_q on the falling edge unless idling.
	// The head stays put until the intake process sees it accepted.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n || command_q.size() == 0 || $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
		end else begin
			push         <= 1'b1;
			opcode       <= command_q[0].op;
			sample_value <= command_q[0].smp;
			position     <= command_q[0].pos;
			step_index   <= command_q[0].idx;
		end
	end

	// Receiver: random pop, plus a long counted hold when requested.
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Intake: every accepted transaction gets its expected result queued.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			answer_q.push_back(apply_command(opcode_t'(opcode), sample_value,
				position, step_index));
			void'(command_q.pop_front());
			accepted++;
		end
		if (arst_n && push && full) full_cycles++;
	end

	// Monitor: each popped result against the oldest expectation.
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && pop && !empty) begin
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR @%0t: result with no transaction pending", $realtime);
			end else begin
				want = answer_q.pop_front();
				checked++;
				status_seen[want.st]++;
				if (interpolated_value !== want.value || lowest_value !== want.lo ||
						highest_value !== want.hi || entry_count !== want.cnt ||
						status !== want.st) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR @%0t result %0d: value %0d/%0d min %0d/%0d",
							$realtime, checked, want.value, interpolated_value,
							want.lo, lowest_value);
						$display("  max %0d/%0d count %0d/%0d status %0d/%0d (exp/act)",
							want.hi, highest_value, want.cnt, entry_count,
							want.st, status);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int k;
		n_samples      = 0;
		run_min        = 16'sh7FFF;
		run_max        = 16'sh8000;
		step_count_cfg = 16'd1;
		send_idle_pct  = 29;
		recv_idle_pct  = 80;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, single entry, extremes, rounding, wrap, clamp
		add_cmd(OP_QPOS,   '0, '0, '0);                   // query on empty table
		add_cmd(OP_QSTEP,  '0, '0, '0);
		add_cmd(OP_APPEND, 16'h1234, '0, '0);             // single entry
		add_cmd(OP_QPOS,   '0, {10'd0, 16'h8000}, '0);    // wraps onto itself
		add_cmd(OP_QPOS,   '0, {POS_W{1'b1}}, '0);        // far past the end
		add_cmd(OP_QSTEP,  '0, '0, 16'd0);
		add_cmd(OP_APPEND, 16'h7FFF, '0, '0);
		add_cmd(OP_APPEND, 16'h8000, '0, '0);
		add_cmd(OP_APPEND, 16'h0000, '0, '0);
		add_cmd(OP_APPEND, 16'hFFFF, '0, '0);
		add_cmd(OP_QPOS,   '0, {10'd1, 16'h8000}, '0);    // full-scale swing
		add_cmd(OP_QPOS,   '0, {10'd1, 16'hFFFF}, '0);
		add_cmd(OP_QPOS,   '0, {10'd3, 16'h8000}, '0);    // 0 -> -1, half rounds up
		add_cmd(OP_QPOS,   '0, {10'd4, 16'h8000}, '0);    // last entry toward entry 0
		add_cmd(OP_QPOS,   '0, {10'd5, 16'h0000}, '0);    // one past last: clamp
		add_cmd(OP_QSTEP,  '0, '0, 16'd1);                // i == total: last entry
		add_cmd(OP_QSTEP,  '0, '0, 16'd2);                // i > total: clamp
		add_cmd(OP_QSTEP,  '0, '0, 16'hFFFF);
		add_cmd(OP_CLEAR,  '0, '0, '0);
		add_cmd(OP_QPOS,   '0, '0, '0);
		add_cmd(OP_APPEND, 16'h8000, '0, '0);
		wait_drained();

		// total of zero behaves as one
		set_step_total(16'd0);
		add_cmd(OP_APPEND, 16'h0064, '0, '0);
		add_cmd(OP_QSTEP,  '0, '0, 16'd1);
		add_cmd(OP_QSTEP,  '0, '0, 16'd0);
		wait_drained();

		// fill to capacity, overflow twice, then query across the whole table
		set_step_total(16'hFFFF);
		add_cmd(OP_CLEAR, '0, '0, '0);
		for (k = 0; k < DEPTH + 2; k++) add_cmd(OP_APPEND, rand_sample(), '0, '0);
		add_cmd(OP_QPOS,  '0, {POS_W{1'b1}}, '0);         // last entry wraps, no clamp
		add_cmd(OP_QPOS,  '0, {10'd1023, 16'h0000}, '0);
		add_cmd(OP_QSTEP, '0, '0, 16'hFFFF);              // lands exactly on last
		for (k = 0; k < 8; k++) begin
			add_cmd(OP_QPOS,  '0, rand_pos(DEPTH), '0);
			add_cmd(OP_QSTEP, '0, '0, rand_step());
		end
		wait_drained();

		// random, small total; receiver stalls long so full backs up intake
		set_step_total(16'($urandom_range(1, 40)));
		hold_token++;
		plan_session(60);
		wait_drained();

		// random, arbitrary total; idle ratios swapped
		send_idle_pct = 80;
		recv_idle_pct = 29;
		set_step_total(16'($urandom));
		plan_session(60);
		wait_drained();

		// random, back to back on both sides, totals of zero and one
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_step_total(16'd0);
		plan_session(30);
		wait_drained();
		set_step_total(16'd1);
		plan_session(30);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d transactions, %0d results checked (ok %0d, full %0d, %s",
			accepted, checked, status_seen[ST_OK], status_seen[ST_FULL],
			$sformatf("empty %0d, clamped %0d)", status_seen[ST_EMPTY],
			status_seen[ST_CLAMP]));
		$display("Intake held off by full for %0d cycles; %0d mismatches",
			full_cycles, mismatches);
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/itl_pkg.sv
rtl/core/itl_ram.sv
rtl/core/itl_queue.sv
rtl/core/itl_front.sv
rtl/core/itl_back.sv
rtl/core/interpolating_table_lookup.sv
verif/tb_interpolating_table_lookup.sv
